@@ sv/bdq_pkg.sv @@
// bdq_pkg: shared types and constants for the bounded deque
// command and status codes, cell control struct, data and count widths
// no dependencies
`default_nettype none

package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    CMD_PEEK       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic fill_tail;
    logic drop_tail;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/bdq_cmd_if.sv @@
// bdq_cmd_if: request channel of the bounded deque
// valid/ready handshake with command and push value, depends on bdq_pkg
`default_nettype none

interface bdq_cmd_if;
  import bdq_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink (input valid, command, push_value, output ready);
endinterface

`default_nettype wire

@@ sv/bdq_res_if.sv @@
// bdq_res_if: result channel of the bounded deque
// valid/ready handshake with popped, front and back values, count and status
// depends on bdq_pkg
`default_nettype none

interface bdq_res_if;
  import bdq_pkg::*;

  logic    valid;
  logic    ready;
  word_t   popped_value;
  word_t   front_value;
  word_t   back_value;
  count_t  entry_count;
  logic    is_empty;
  status_t status;

  modport source (output valid, popped_value, front_value, back_value, entry_count,
                  is_empty, status, input ready);
  modport sink (input valid, popped_value, front_value, back_value, entry_count,
                is_empty, status, output ready);
endinterface

`default_nettype wire

@@ sv/bounded_deque_top.sv @@
// bounded_deque_top: double-ended queue of signed 32-bit values on a chain of cells
// depends on bdq_pkg, bdq_cmd_if, bdq_res_if and bdq_cell
//
// The queue holds up to DEPTH (16) values in a row of cells, the front in cell 0 and
// the back in the last occupied cell. A request is taken in every cycle in which the
// result register is free or being emptied, so one request per cycle is sustained;
// each result is registered, appears in the cycle after its request and is held until
// taken. On a push or pop at the front every cell loads its neighbor's value together,
// cell 0 taking the push value. Reset empties the queue at once, with no clearing pass.
`default_nettype none

module bounded_deque_top (
  input wire        clk,
  input wire        rst,
  bdq_cmd_if.sink   cmd,
  bdq_res_if.source res
);
  import bdq_pkg::*;

  cell_ctrl_t ctrl;
  word_t      cell_data [DEPTH];
  logic       cell_occ [DEPTH];
  word_t      cell_data_next [DEPTH];
  logic       cell_occ_next [DEPTH];
  word_t      left_data [DEPTH];
  logic       left_valid [DEPTH];
  word_t      right_data [DEPTH];
  logic       right_valid [DEPTH];

  count_t  count;
  count_t  count_next;
  status_t status_next;
  word_t   popped_next;
  word_t   cur_back;
  word_t   front_next;
  word_t   back_next;
  logic    accept;
  logic    full;
  logic    empty;

  logic    out_valid;
  word_t   out_popped;
  word_t   out_front;
  word_t   out_back;
  count_t  out_count;
  logic    out_empty;
  status_t out_status;

  assign cmd.ready = !out_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == count_t'(DEPTH));
  assign empty     = (count == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i]  = cmd.push_value;
      assign left_valid[i] = 1'b1;
    end else begin : g_inner_l
      assign left_data[i]  = cell_data[i-1];
      assign left_valid[i] = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data[i]  = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_inner_r
      assign right_data[i]  = cell_data[i+1];
      assign right_valid[i] = cell_occ[i+1];
    end

    bdq_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .push_value    (cmd.push_value),
      .left_data     (left_data[i]),
      .left_valid    (left_valid[i]),
      .right_data    (right_data[i]),
      .right_valid   (right_valid[i]),
      .data          (cell_data[i]),
      .occupied      (cell_occ[i]),
      .data_next     (cell_data_next[i]),
      .occupied_next (cell_occ_next[i])
    );
  end

  // back value: the occupied cell whose right neighbor is free
  always_comb begin
    cur_back  = '0;
    back_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_occ[i] && (i == DEPTH - 1 || !cell_occ[(i + 1) % DEPTH])) begin
        cur_back = cur_back | cell_data[i];
      end
      if (cell_occ_next[i] && (i == DEPTH - 1 || !cell_occ_next[(i + 1) % DEPTH])) begin
        back_next = back_next | cell_data_next[i];
      end
    end
    front_next = cell_occ_next[0] ? cell_data_next[0] : '0;
  end

  always_comb begin
    ctrl        = '0;
    count_next  = count;
    status_next = ST_OK;
    popped_next = '0;
    case (cmd.command)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          ctrl.shift_right = accept;
          count_next       = count + count_t'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          ctrl.fill_tail = accept;
          count_next     = count + count_t'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          ctrl.shift_left = accept;
          count_next      = count - count_t'(1);
          popped_next     = cell_data[0];
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          ctrl.drop_tail = accept;
          count_next     = count - count_t'(1);
          popped_next    = cur_back;
        end
      end
      CMD_CLEAR: begin
        ctrl.clear = accept;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      out_popped <= popped_next;
      out_front  <= front_next;
      out_back   <= back_next;
      out_count  <= count_next;
      out_empty  <= (count_next == '0);
      out_status <= status_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.popped_value = out_popped;
  assign res.front_value  = out_front;
  assign res.back_value   = out_back;
  assign res.entry_count  = out_count;
  assign res.is_empty     = out_empty;
  assign res.status       = out_status;

endmodule

`default_nettype wire

@@ sv/bdq_cell.sv @@
// bdq_cell: one storage position of the deque chain
// holds a value and an occupied flag, trades data with its neighbors
// depends on bdq_pkg
`default_nettype none

module bdq_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  bdq_pkg::word_t      push_value,
  input  bdq_pkg::word_t      left_data,
  input  wire                 left_valid,
  input  bdq_pkg::word_t      right_data,
  input  wire                 right_valid,
  output bdq_pkg::word_t      data,
  output logic                occupied,
  output bdq_pkg::word_t      data_next,
  output logic                occupied_next
);
  import bdq_pkg::*;

  always_comb begin
    data_next     = data;
    occupied_next = occupied;
    if (ctrl.clear) begin
      occupied_next = 1'b0;
    end else if (ctrl.shift_right) begin
      data_next     = left_data;
      occupied_next = left_valid;
    end else if (ctrl.shift_left) begin
      data_next     = right_data;
      occupied_next = right_valid;
    end else if (ctrl.fill_tail && !occupied && left_valid) begin
      data_next     = push_value;
      occupied_next = 1'b1;
    end else if (ctrl.drop_tail && occupied && !right_valid) begin
      occupied_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      occupied <= 1'b0;
    end else begin
      occupied <= occupied_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/bdq_checker.sv @@
// bdq_checker: port-level assertions for bounded_deque_top
// bound to the top level below, depends on bdq_pkg
`default_nettype none

module bdq_checker (
  input wire             clk,
  input wire             rst,
  input wire             res_valid,
  input wire             res_ready,
  input bdq_pkg::word_t  popped_value,
  input bdq_pkg::word_t  front_value,
  input bdq_pkg::word_t  back_value,
  input bdq_pkg::count_t entry_count,
  input wire             is_empty,
  input bdq_pkg::status_t status
);
  import bdq_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(popped_value) && $stable(entry_count))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_empty |-> front_value == '0 && back_value == '0)
    else $error("front or back nonzero on empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> entry_count <= count_t'(DEPTH))
    else $error("count above depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_POP_EMPTY |-> popped_value == '0 && is_empty)
    else $error("pop from empty returned data");

endmodule

bind bounded_deque_top bdq_checker u_bdq_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .popped_value (res.popped_value),
  .front_value  (res.front_value),
  .back_value   (res.back_value),
  .entry_count  (res.entry_count),
  .is_empty     (res.is_empty),
  .status       (res.status)
);

`default_nettype wire
